@@ rtl/csm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csm_pkg;

    localparam int CSM_COORD_WIDTH = 20;
    localparam int CSM_TAP_W       = 16;
    localparam int CSM_REG_IDX_W   = 3;
    localparam int CSM_EDGE_REPEAT = 3;
    localparam int CSM_RND_SHIFT   = 28;

    localparam logic [CSM_TAP_W-1:0] CSM_TAP_CENTER_RST = 16'd16384;
    localparam logic [CSM_TAP_W-1:0] CSM_NORM_GAIN_RST  = 16'd16384;

    typedef enum logic [CSM_REG_IDX_W-1:0] {
        REG_TAP_CENTER = 3'd0,
        REG_TAP_ONE    = 3'd1,
        REG_TAP_TWO    = 3'd2,
        REG_TAP_THREE  = 3'd3,
        REG_NORM_GAIN  = 3'd4
    } csm_reg_idx_t;

    typedef struct packed {
        logic [CSM_TAP_W-1:0] tap_center;
        logic [CSM_TAP_W-1:0] tap_one;
        logic [CSM_TAP_W-1:0] tap_two;
        logic [CSM_TAP_W-1:0] tap_three;
        logic [CSM_TAP_W-1:0] norm_gain;
    } csm_kernel_t;

    typedef struct packed {
        logic fill;
        logic shift;
        logic start;
    } csm_lane_ctrl_t;

    typedef enum logic [2:0] {
        PH_CENTER = 3'd0,
        PH_ONE    = 3'd1,
        PH_TWO    = 3'd2,
        PH_THREE  = 3'd3,
        PH_LOW    = 3'd4,
        PH_HIGH   = 3'd5,
        PH_ROUND  = 3'd6
    } csm_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_CALC = 4'b0100,
        ST_EMIT = 4'b1000
    } csm_state_t;

endpackage

`default_nettype wire

@@ rtl/csm_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csm_lane
    import csm_pkg::*;
#(
    parameter int COORD_WIDTH = CSM_COORD_WIDTH
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire csm_lane_ctrl_t                ctrl,
    input  wire logic signed [COORD_WIDTH-1:0] point,
    input  wire csm_kernel_t                   kernel,
    output logic signed [COORD_WIDTH-1:0]      result,
    output logic                               done
);

    localparam int SUM_W  = COORD_WIDTH + 1;
    localparam int ACC_W  = SUM_W + CSM_TAP_W + 2;
    localparam int HI_W   = ACC_W - SUM_W;
    localparam int MA_W   = (SUM_W + 1 > HI_W) ? SUM_W + 1 : HI_W;
    localparam int MB_W   = CSM_TAP_W + 1;
    localparam int PR_W   = MA_W + MB_W;
    localparam int TOT_W  = ACC_W + MB_W;
    localparam int RW     = TOT_W - CSM_RND_SHIFT;
    localparam int WIN    = 2 * CSM_EDGE_REPEAT + 1;

    localparam logic signed [TOT_W-1:0] RND_HALF =
        {{(TOT_W-CSM_RND_SHIFT){1'b0}}, 1'b1, {(CSM_RND_SHIFT-1){1'b0}}};
    localparam logic signed [RW-1:0] R_MAX =
        {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [RW-1:0] R_MIN =
        {{(RW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] window_reg [WIN];
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [TOT_W-1:0]       tot_reg;
    logic signed [COORD_WIDTH-1:0] result_reg;
    logic                          busy_reg;
    logic                          done_reg;
    csm_phase_t                    phase_reg;

    logic signed [SUM_W-1:0]       pair_one;
    logic signed [SUM_W-1:0]       pair_two;
    logic signed [SUM_W-1:0]       pair_three;
    logic signed [MA_W-1:0]        mul_a;
    logic signed [MB_W-1:0]        mul_b;
    logic signed [PR_W-1:0]        prod;
    logic signed [RW-1:0]          rounded;
    logic signed [COORD_WIDTH-1:0] sat;

    assign pair_one   = SUM_W'(window_reg[2]) + SUM_W'(window_reg[4]);
    assign pair_two   = SUM_W'(window_reg[1]) + SUM_W'(window_reg[5]);
    assign pair_three = SUM_W'(window_reg[0]) + SUM_W'(window_reg[6]);

    // one shared multiplier per lane, one product per phase
    always_comb
    begin
        case (phase_reg)
            PH_CENTER:
            begin
                mul_a = MA_W'(window_reg[3]);
                mul_b = signed'({1'b0, kernel.tap_center});
            end
            PH_ONE:
            begin
                mul_a = MA_W'(pair_one);
                mul_b = signed'({1'b0, kernel.tap_one});
            end
            PH_TWO:
            begin
                mul_a = MA_W'(pair_two);
                mul_b = signed'({1'b0, kernel.tap_two});
            end
            PH_THREE:
            begin
                mul_a = MA_W'(pair_three);
                mul_b = signed'({1'b0, kernel.tap_three});
            end
            PH_LOW:
            begin
                mul_a = signed'(MA_W'(acc_reg[SUM_W-1:0]));
                mul_b = signed'({1'b0, kernel.norm_gain});
            end
            PH_HIGH:
            begin
                mul_a = MA_W'(signed'(acc_reg[ACC_W-1:SUM_W]));
                mul_b = signed'({1'b0, kernel.norm_gain});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign rounded = RW'(tot_reg >>> CSM_RND_SHIFT);

    always_comb
    begin
        if (rounded > R_MAX)
        begin
            sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        else if (rounded < R_MIN)
        begin
            sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat = rounded[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fill)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                window_reg[i] <= point;
            end
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < WIN - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[WIN-1] <= point;
        end

        if (busy_reg)
        begin
            case (phase_reg)
                PH_CENTER:                   acc_reg <= ACC_W'(prod);
                PH_ONE, PH_TWO, PH_THREE:    acc_reg <= acc_reg + ACC_W'(prod);
                PH_LOW:                      tot_reg <= TOT_W'(prod);
                PH_HIGH:
                begin
                    tot_reg <= tot_reg + (TOT_W'(prod) <<< SUM_W) + RND_HALF;
                end
                PH_ROUND:                    result_reg <= sat;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_CENTER;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_CENTER;
            end
            else if (busy_reg)
            begin
                if (phase_reg == PH_ROUND)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= csm_phase_t'(phase_reg + 3'd1);
                end
            end
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

@@ rtl/csm_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csm_merge
    import csm_pkg::*;
#(
    parameter int COORD_WIDTH = CSM_COORD_WIDTH,
    parameter int TDATA_W     = ((2 * COORD_WIDTH + 7) / 8) * 8
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire logic signed [COORD_WIDTH-1:0] lane_x,
    input  wire logic signed [COORD_WIDTH-1:0] lane_y,
    input  wire logic                          last,
    output logic                               slot_free,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [TDATA_W-1:0]                 m_axis_tdata,  // smooth_x, smooth_y
    output logic                               m_axis_tlast   // last_out
);

    logic               valid_reg;
    logic [TDATA_W-1:0] data_reg;
    logic               last_reg;

    assign slot_free = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // both lanes packed into one beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= TDATA_W'({lane_y, lane_x});
            last_reg <= last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

@@ rtl/curve_gaussian_smoother.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Seven-tap symmetric smoothing of a 2-D curve, x and y in two lanes with
// the ends of each curve extended by repeating the first and last point
// three times. Results lag the input by three points; the beat with tlast
// flushes the rest, so a curve of n points yields n results and the last
// carries tlast. One point is taken at a time: no new point is accepted
// until the block is through with the current one. The single multiplier
// in each lane makes seven passes per result (four taps, two gain halves,
// rounding), and output stalls hold the block further. Registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them
// only while no point is in progress, as the block does not enforce it.
module curve_gaussian_smoother
    import csm_pkg::*;
#(
    parameter int COORD_WIDTH = CSM_COORD_WIDTH,
    localparam int TDATA_W    = ((2 * COORD_WIDTH + 7) / 8) * 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CSM_REG_IDX_W-1:0] cfg_index,
    input  wire logic [CSM_TAP_W-1:0]     cfg_data,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [TDATA_W-1:0]       s_axis_tdata,  // point_x, point_y
    input  wire logic                     s_axis_tlast,  // end_of_curve
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [TDATA_W-1:0]            m_axis_tdata,  // smooth_x, smooth_y
    output logic                          m_axis_tlast   // last_out
);

    csm_kernel_t                   kernel_reg;
    csm_state_t                    state_reg;
    csm_state_t                    state_next;
    logic signed [COORD_WIDTH-1:0] px_reg;
    logic signed [COORD_WIDTH-1:0] py_reg;
    logic                          last_reg;
    logic [1:0]                    c_reg;
    logic [1:0]                    s_reg;
    logic [1:0]                    s_next;
    logic [1:0]                    seen_reg;
    logic [1:0]                    seen_next;

    csm_lane_ctrl_t                lane_ctrl;
    logic signed [COORD_WIDTH-1:0] lane_x;
    logic signed [COORD_WIDTH-1:0] lane_y;
    logic                          done_x;
    logic                          done_y;
    logic                          slot_free;
    logic                          load;
    logic                          accept;
    logic                          need_emit;
    logic                          final_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg.tap_center <= CSM_TAP_CENTER_RST;
            kernel_reg.tap_one    <= '0;
            kernel_reg.tap_two    <= '0;
            kernel_reg.tap_three  <= '0;
            kernel_reg.norm_gain  <= CSM_NORM_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TAP_CENTER: kernel_reg.tap_center <= cfg_data;
                REG_TAP_ONE:    kernel_reg.tap_one    <= cfg_data;
                REG_TAP_TWO:    kernel_reg.tap_two    <= cfg_data;
                REG_TAP_THREE:  kernel_reg.tap_three  <= cfg_data;
                REG_NORM_GAIN:  kernel_reg.norm_gain  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign need_emit  = ({1'b0, c_reg} + {1'b0, s_reg}) >= 3'(CSM_EDGE_REPEAT);
    assign final_step = last_reg ? (s_reg == 2'(CSM_EDGE_REPEAT)) : (s_reg == 2'd0);

    always_comb
    begin
        if (s_axis_tlast)
        begin
            seen_next = 2'd0;
        end
        else if (seen_reg < 2'(CSM_EDGE_REPEAT))
        begin
            seen_next = seen_reg + 2'd1;
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_next     = s_reg;
        lane_ctrl  = '0;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_STEP;
                    s_next     = 2'd0;
                end
            end
            ST_STEP:
            begin
                // first point of a curve loads the whole window
                lane_ctrl.fill  = (c_reg == 2'd0) && (s_reg == 2'd0);
                lane_ctrl.shift = !lane_ctrl.fill;
                lane_ctrl.start = need_emit;
                if (need_emit)
                begin
                    state_next = ST_CALC;
                end
                else if (final_step)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    s_next = s_reg + 2'd1;
                end
            end
            ST_CALC:
            begin
                if (done_x && done_y)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    if (final_step)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                        s_next     = s_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            s_reg     <= 2'd0;
            c_reg     <= 2'd0;
            seen_reg  <= 2'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s_reg     <= s_next;
            if (accept)
            begin
                c_reg    <= seen_reg;
                seen_reg <= seen_next;
                last_reg <= s_axis_tlast;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= s_axis_tdata[COORD_WIDTH-1:0];
            py_reg <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        end
    end

    csm_lane #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .point  (px_reg),
        .kernel (kernel_reg),
        .result (lane_x),
        .done   (done_x)
    );

    csm_lane #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .point  (py_reg),
        .kernel (kernel_reg),
        .result (lane_y),
        .done   (done_y)
    );

    csm_merge #(
        .COORD_WIDTH (COORD_WIDTH),
        .TDATA_W     (TDATA_W)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .lane_x        (lane_x),
        .lane_y        (lane_y),
        .last          (last_reg && final_step),
        .slot_free     (slot_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
